FILE: hw/rtl/dgoe_pkg.sv
// Shared types and constants of the deblocking grid offset estimator.
package dgoe_pkg;

    localparam int NUM_BINS    = 8;
    localparam int IDX_W       = $clog2(NUM_BINS);
    localparam int BIN_W       = 16;
    localparam int SUM_W       = BIN_W + $clog2(NUM_BINS);
    localparam int DIV_W       = (SUM_W > 20) ? SUM_W : 20;
    localparam int DIV_STEPS   = 2;
    localparam int DIV_ITER    = (DIV_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DCNT_W      = $clog2(DIV_ITER + 1);
    localparam int OFF_W       = 3;
    localparam int CONF_W      = 4;
    localparam int CTRL_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PROD_W      = DIV_W + CONF_W;
    localparam int AVG_SHIFT   = SUM_W + $clog2(NUM_BINS);
    localparam int AVG_MULT    = ((1 << AVG_SHIFT) + NUM_BINS - 2) / (NUM_BINS - 1);
    localparam int AVG_PROD_W  = SUM_W + AVG_SHIFT;

    localparam logic [OFF_W-1:0] OFFSET_RESET = 3'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PEAK = 2'd0,
        CFG_GAIN     = 2'd1,
        CFG_MAX_CONF = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_AVG,
        BK_RATIO,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        logic             dir;
        logic [BIN_W-1:0] peak;
        logic [SUM_W-1:0] sum;
        logic [IDX_W-1:0] index;
    } t_hist;

    typedef struct packed {
        logic [BIN_W-1:0]  min_peak;
        logic [CONF_W-1:0] gain;
        logic [CONF_W-1:0] max_conf;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

endpackage

FILE: hw/rtl/dgoe_front.sv
// Front end: accepts bins, keeps the running sum and peak, and queues each finished histogram.
module dgoe_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [dgoe_pkg::BIN_W-1:0]      i_bin_value,
    input  logic                            i_vertical,
    input  logic                            i_q_full,
    output logic                            o_push,
    output dgoe_pkg::t_hist                 o_entry
);
    import dgoe_pkg::*;

    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [BIN_W-1:0] r_peak, n_peak;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_dir, n_dir;
    logic             first;
    logic             last;
    logic             accept;

    assign first   = (r_cnt == '0);
    assign last    = (r_cnt == IDX_W'(NUM_BINS - 1));
    assign o_ready = !(last && i_q_full);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_dir  = first ? i_vertical : r_dir;
        n_sum  = (first ? '0 : r_sum) + SUM_W'(i_bin_value);
        n_peak = first ? '0 : r_peak;
        n_idx  = first ? '0 : r_idx;
        if (i_bin_value > n_peak) begin
            n_peak = i_bin_value;
            n_idx  = r_cnt;
        end
        n_cnt = last ? '0 : r_cnt + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sum  <= n_sum;
            r_peak <= n_peak;
            r_idx  <= n_idx;
            r_dir  <= n_dir;
        end
    end

    assign o_push        = accept && last;
    assign o_entry.dir   = n_dir;
    assign o_entry.peak  = n_peak;
    assign o_entry.sum   = n_sum;
    assign o_entry.index = n_idx;

endmodule

FILE: hw/rtl/dgoe_queue.sv
// Short queue of finished histograms between the front and back ends.
module dgoe_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dgoe_pkg::t_hist i_entry,
    output logic            o_full,
    output logic            o_valid,
    output dgoe_pkg::t_hist o_entry,
    input  logic            i_pop
);
    import dgoe_pkg::*;

    t_hist             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_entry = r_mem[r_rd];

    function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] ptr);
        return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (do_pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

FILE: hw/rtl/dgoe_divider.sv
// Restoring divider that retires two quotient bits per cycle.
module dgoe_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dgoe_pkg::t_div_req i_req,
    output dgoe_pkg::t_div_rsp o_rsp
);
    import dgoe_pkg::*;

    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_q, n_q;
    logic [DIV_W-1:0]  r_den;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    always_comb begin
        logic [DIV_W:0] trial;
        n_rem = r_rem;
        n_q   = r_q;
        for (int s = 0; s < DIV_STEPS; s++) begin
            trial = {n_rem, n_q[DIV_W-1]};
            n_q   = {n_q[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                trial  = trial - {1'b0, r_den};
                n_q[0] = 1'b1;
            end
            n_rem = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DCNT_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIV_ITER);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

FILE: hw/rtl/dgoe_back.sv
// Back end: works out the confidence, keeps both directions and holds the result item.
module dgoe_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dgoe_pkg::t_cfg                i_cfg,
    input  logic                          i_q_valid,
    input  dgoe_pkg::t_hist               i_q_entry,
    output logic                          o_q_pop,
    output dgoe_pkg::t_div_req            o_div_req,
    input  dgoe_pkg::t_div_rsp            i_div_rsp,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_is_vertical,
    output logic [dgoe_pkg::OFF_W-1:0]    o_grid_offset,
    output logic [dgoe_pkg::CONF_W-1:0]   o_confidence_level,
    output logic [dgoe_pkg::CTRL_W-1:0]   o_control_word
);
    import dgoe_pkg::*;

    t_back_state           r_state, n_state;
    t_hist                 r_item;
    logic [CONF_W-1:0]     r_conf, n_conf;
    logic                  conf_load;
    logic                  out_load;
    logic                  r_out_valid;
    logic                  r_out_dir;
    logic [OFF_W-1:0]      r_out_off;
    logic [CONF_W-1:0]     r_out_conf;
    logic [CTRL_W-1:0]     r_out_ctrl;
    logic [OFF_W-1:0]      r_h_off, r_v_off, n_h_off, n_v_off;
    logic [CONF_W-1:0]     r_h_conf, r_v_conf, n_h_conf, n_v_conf;
    logic [OFF_W-1:0]      item_off;
    logic [DIV_W-1:0]      q_dec;
    logic [PROD_W-1:0]     prod;
    logic [SUM_W-1:0]      avg_num;
    logic [AVG_PROD_W-1:0] avg_prod;
    logic [SUM_W-1:0]      avg;

    assign q_dec = i_div_rsp.quot - DIV_W'(i_div_rsp.quot != '0);
    assign prod  = PROD_W'(q_dec) * PROD_W'(i_cfg.gain);

    assign avg_num  = r_item.sum - SUM_W'(r_item.peak);
    assign avg_prod = AVG_PROD_W'(avg_num) * AVG_PROD_W'(AVG_MULT);
    assign avg      = avg_prod[AVG_PROD_W-1:AVG_SHIFT];

    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        o_div_req = '0;
        conf_load = 1'b0;
        n_conf    = r_conf;
        out_load  = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_entry.peak < i_cfg.min_peak) begin
                        conf_load = 1'b1;
                        n_conf    = '0;
                        n_state   = BK_DONE;
                    end else begin
                        n_state   = BK_AVG;
                    end
                end
            end
            BK_AVG: begin
                if (avg == '0) begin
                    conf_load = 1'b1;
                    n_conf    = i_cfg.max_conf;
                    n_state   = BK_DONE;
                end else begin
                    o_div_req.start = 1'b1;
                    o_div_req.num   = DIV_W'({r_item.peak, 3'b000})
                                    + DIV_W'({r_item.peak, 1'b0}) + DIV_W'(5);
                    o_div_req.den   = DIV_W'({avg, 3'b000}) + DIV_W'({avg, 1'b0});
                    n_state         = BK_RATIO;
                end
            end
            BK_RATIO: begin
                if (i_div_rsp.done) begin
                    conf_load = 1'b1;
                    n_conf    = (prod > PROD_W'(i_cfg.max_conf)) ? i_cfg.max_conf
                                                                : prod[CONF_W-1:0];
                    n_state   = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign item_off = OFF_W'(r_item.index);

    always_comb begin
        n_h_off  = r_h_off;
        n_h_conf = r_h_conf;
        n_v_off  = r_v_off;
        n_v_conf = r_v_conf;
        if (r_item.dir) begin
            n_v_off  = item_off;
            n_v_conf = r_conf;
        end else begin
            n_h_off  = item_off;
            n_h_conf = r_conf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_h_off     <= OFFSET_RESET;
            r_v_off     <= OFFSET_RESET;
            r_h_conf    <= '0;
            r_v_conf    <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_h_off     <= n_h_off;
                r_v_off     <= n_v_off;
                r_h_conf    <= n_h_conf;
                r_v_conf    <= n_v_conf;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_entry;
        end
        if (conf_load) begin
            r_conf <= n_conf;
        end
        if (out_load) begin
            r_out_dir  <= r_item.dir;
            r_out_off  <= item_off;
            r_out_conf <= r_conf;
            r_out_ctrl <= {n_h_conf, n_v_conf, 1'b0, n_h_off, 1'b0, n_v_off};
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_is_vertical      = r_out_dir;
    assign o_grid_offset      = r_out_off;
    assign o_confidence_level = r_out_conf;
    assign o_control_word     = r_out_ctrl;

    a_done_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |-> (r_state == BK_RATIO))
        else $error("Divider finished while the back end was not waiting for it.");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DONE && (!r_out_valid || i_out_ready)) |=> r_out_valid)
        else $error("A finished item did not reach the output register.");

    a_ctrl_matches_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_ctrl == {r_h_conf, r_v_conf, 1'b0, r_h_off, 1'b0, r_v_off}))
        else $error("Control word disagrees with the stored offsets and confidences.");

    a_item_matches_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_dir ? (r_out_off == r_v_off && r_out_conf == r_v_conf)
                                   : (r_out_off == r_h_off && r_out_conf == r_h_conf)))
        else $error("Result item disagrees with the stored values of its direction.");

endmodule

FILE: hw/rtl/deblock_grid_offset_estimator_top.sv
// Top level of the deblocking grid offset estimator.
// Bins are taken one per cycle while the two-entry histogram queue has room. Each
// finished histogram then passes through the back end: it is taken from the queue,
// the average of the other bins is formed by a reciprocal multiplication, the
// divider retires two quotient bits per cycle to form the peak ratio, and the result
// item is loaded. A histogram whose peak is below min_peak, or whose average is
// zero, skips the division. The result item waits in an output register while the
// next histogram is loaded. Configuration writes are always accepted; an index
// beyond the three registers is ignored.
module deblock_grid_offset_estimator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [dgoe_pkg::BIN_W-1:0]        i_bin_value,
    input  logic                              i_vertical,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_is_vertical,
    output logic [dgoe_pkg::OFF_W-1:0]        o_grid_offset,
    output logic [dgoe_pkg::CONF_W-1:0]       o_confidence_level,
    output logic [dgoe_pkg::CTRL_W-1:0]       o_control_word,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dgoe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dgoe_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import dgoe_pkg::*;

    t_cfg     r_cfg;
    logic     q_full;
    logic     q_push;
    t_hist    q_in;
    logic     q_valid;
    t_hist    q_out;
    logic     q_pop;
    t_div_req div_req;
    t_div_rsp div_rsp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_peak <= BIN_W'(200);
            r_cfg.gain     <= CONF_W'(1);
            r_cfg.max_conf <= CONF_W'(8);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_PEAK: r_cfg.min_peak <= i_cfg_data[BIN_W-1:0];
                CFG_GAIN:     r_cfg.gain     <= i_cfg_data[CONF_W-1:0];
                CFG_MAX_CONF: r_cfg.max_conf <= i_cfg_data[CONF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dgoe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_bin_value (i_bin_value),
        .i_vertical  (i_vertical),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_entry     (q_in)
    );

    dgoe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_out),
        .i_pop   (q_pop)
    );

    dgoe_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    dgoe_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_q_valid          (q_valid),
        .i_q_entry          (q_out),
        .o_q_pop            (q_pop),
        .o_div_req          (div_req),
        .i_div_rsp          (div_rsp),
        .o_out_valid        (o_valid),
        .i_out_ready        (i_ready),
        .o_is_vertical      (o_is_vertical),
        .o_grid_offset      (o_grid_offset),
        .o_confidence_level (o_confidence_level),
        .o_control_word     (o_control_word)
    );

endmodule

FILE: dv/grid_offset_checker.sv
// Checker that predicts each histogram's offset and confidence result and compares it at the output.
module grid_offset_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_bin_valid,
    input  logic                            i_bin_ready,
    input  logic [dgoe_pkg::BIN_W-1:0]      i_bin_value,
    input  logic                            i_vertical,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  logic                            i_is_vertical,
    input  logic [dgoe_pkg::OFF_W-1:0]      i_grid_offset,
    input  logic [dgoe_pkg::CONF_W-1:0]     i_confidence_level,
    input  logic [dgoe_pkg::CTRL_W-1:0]     i_control_word,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [dgoe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dgoe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import dgoe_pkg::*;

    typedef struct packed {
        logic              vertical;
        logic [OFF_W-1:0]  offset;
        logic [CONF_W-1:0] level;
        logic [CTRL_W-1:0] ctrl;
    } t_offset_result;

    t_offset_result    expected_offsets[$];
    logic [BIN_W-1:0]  min_peak_q;
    logic [CONF_W-1:0] gain_q;
    logic [CONF_W-1:0] max_conf_q;
    int unsigned       bins_seen;
    int unsigned       bin_total;
    int unsigned       peak_q;
    int unsigned       peak_at;
    logic              dir_q;
    logic [OFF_W-1:0]  h_offset;
    logic [OFF_W-1:0]  v_offset;
    logic [CONF_W-1:0] h_level;
    logic [CONF_W-1:0] v_level;

    function automatic logic [CONF_W-1:0] grade_peak(input int unsigned peak,
                                                     input int unsigned total);
        int unsigned avg;
        int unsigned ratio;
        if (peak < 32'(min_peak_q)) begin
            return '0;
        end
        avg = (total - peak) / unsigned'(NUM_BINS - 1);
        if (avg == 0) begin
            return max_conf_q;
        end
        ratio = (peak * 10 + 5) / (avg * 10);
        if (ratio > 0) begin
            ratio--;
        end
        ratio = ratio * 32'(gain_q);
        if (ratio > 32'(max_conf_q)) begin
            ratio = 32'(max_conf_q);
        end
        return ratio[CONF_W-1:0];
    endfunction

    function automatic void check_field(input string name, input logic [CTRL_W-1:0] want,
                                        input logic [CTRL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : track
        t_offset_result    want;
        logic [CONF_W-1:0] level;
        if (!i_rst_n) begin
            o_fail_count = 0;
            min_peak_q = 16'd200;
            gain_q = 4'd1;
            max_conf_q = 4'd8;
            bins_seen = 0;
            bin_total = 0;
            peak_q = 0;
            peak_at = 0;
            dir_q = 1'b0;
            h_offset = OFFSET_RESET;
            v_offset = OFFSET_RESET;
            h_level = '0;
            v_level = '0;
            expected_offsets.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIN_PEAK: min_peak_q = i_cfg_data[BIN_W-1:0];
                    CFG_GAIN:     gain_q = i_cfg_data[CONF_W-1:0];
                    CFG_MAX_CONF: max_conf_q = i_cfg_data[CONF_W-1:0];
                    default: ;
                endcase
            end

            if (i_res_valid && i_res_ready) begin
                if (expected_offsets.size() == 0) begin
                    $error("result item with no prediction waiting: offset %0d, level %0d",
                           i_grid_offset, i_confidence_level);
                    o_fail_count++;
                end else begin
                    want = expected_offsets.pop_front();
                    check_field("is_vertical", CTRL_W'(want.vertical),
                                CTRL_W'(i_is_vertical));
                    check_field("grid_offset", CTRL_W'(want.offset),
                                CTRL_W'(i_grid_offset));
                    check_field("confidence_level", CTRL_W'(want.level),
                                CTRL_W'(i_confidence_level));
                    check_field("control_word", want.ctrl, i_control_word);
                end
            end

            if (i_bin_valid && i_bin_ready) begin
                if (bins_seen == 0) begin
                    dir_q = i_vertical;
                    bin_total = 0;
                    peak_q = 0;
                    peak_at = 0;
                end
                bin_total += 32'(i_bin_value);
                if (32'(i_bin_value) > peak_q) begin
                    peak_q = 32'(i_bin_value);
                    peak_at = bins_seen;
                end
                if (bins_seen + 1 < NUM_BINS) begin
                    bins_seen++;
                end else begin
                    bins_seen = 0;
                    level = grade_peak(peak_q, bin_total);
                    if (dir_q) begin
                        v_offset = peak_at[OFF_W-1:0];
                        v_level = level;
                    end else begin
                        h_offset = peak_at[OFF_W-1:0];
                        h_level = level;
                    end
                    want = '{dir_q, peak_at[OFF_W-1:0], level,
                             {h_level, v_level, 1'b0, h_offset, 1'b0, v_offset}};
                    expected_offsets.push_back(want);
                end
            end
        end
        o_pending = expected_offsets.size();
    end

endmodule

FILE: dv/testbench.sv
// Testbench top: clock, reset, histogram and register stimulus, and the final verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dgoe_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int PHASES          = 8;
    localparam int HISTS_PER_PHASE = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  bin_valid;
    logic                  bin_ready;
    logic [BIN_W-1:0]      bin_value;
    logic                  bin_vertical;
    logic                  res_valid;
    logic                  res_ready;
    logic                  res_is_vertical;
    logic [OFF_W-1:0]      res_grid_offset;
    logic [CONF_W-1:0]     res_level;
    logic [CTRL_W-1:0]     res_ctrl;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  idle_on;
    int                    fail_count;
    int                    pending;
    logic [BIN_W-1:0]      hist_bins [NUM_BINS];

    deblock_grid_offset_estimator_top dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_valid            (bin_valid),
        .o_ready            (bin_ready),
        .i_bin_value        (bin_value),
        .i_vertical         (bin_vertical),
        .o_valid            (res_valid),
        .i_ready            (res_ready),
        .o_is_vertical      (res_is_vertical),
        .o_grid_offset      (res_grid_offset),
        .o_confidence_level (res_level),
        .o_control_word     (res_ctrl),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    grid_offset_checker offset_check (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_bin_valid        (bin_valid),
        .i_bin_ready        (bin_ready),
        .i_bin_value        (bin_value),
        .i_vertical         (bin_vertical),
        .i_res_valid        (res_valid),
        .i_res_ready        (res_ready),
        .i_is_vertical      (res_is_vertical),
        .i_grid_offset      (res_grid_offset),
        .i_confidence_level (res_level),
        .i_control_word     (res_ctrl),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles == CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin : result_sink
        int hold;
        res_ready = 1'b0;
        hold = 0;
        forever begin
            @(negedge clk);
            if (hold > 0) begin
                res_ready <= 1'b0;
                hold--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 11) - 1;
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    task automatic send_bin(input logic [BIN_W-1:0] value, input logic vert);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
            bin_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        bin_valid <= 1'b1;
        bin_value <= value;
        bin_vertical <= vert;
        @(posedge clk);
        while (!bin_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_histogram(input logic dir);
        for (int i = 0; i < NUM_BINS; i++) begin
            send_bin(hist_bins[i], (i == 0) ? dir : 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic shape_histogram();
        int pick;
        int base_level;
        int crest;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            base_level = $urandom_range(0, 3000);
            foreach (hist_bins[i]) begin
                hist_bins[i] = BIN_W'(base_level + $urandom_range(0, base_level / 4));
            end
            crest = base_level * $urandom_range(1, 24) + $urandom_range(0, 255);
            if (crest > 65535) begin
                crest = 65535;
            end
            hist_bins[$urandom_range(0, NUM_BINS - 1)] = BIN_W'(crest);
        end else if (pick == 6) begin
            base_level = $urandom_range(0, 65535);
            foreach (hist_bins[i]) begin
                hist_bins[i] = BIN_W'(base_level);
            end
            crest = base_level + $urandom_range(0, 65535 - base_level);
            hist_bins[$urandom_range(0, NUM_BINS - 1)] = BIN_W'(crest);
            hist_bins[$urandom_range(0, NUM_BINS - 1)] = BIN_W'(crest);
        end else if (pick == 7) begin
            foreach (hist_bins[i]) begin
                hist_bins[i] = $urandom_range(0, 1) ? '0 : BIN_W'($urandom_range(0, 6));
            end
            hist_bins[$urandom_range(0, NUM_BINS - 1)] = BIN_W'($urandom_range(0, 65535));
        end else begin
            foreach (hist_bins[i]) begin
                hist_bins[i] = BIN_W'($urandom_range(0, 65535));
            end
        end
    endtask

    task automatic program_register(input logic [CFG_IDX_W-1:0] which,
                                    input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic configure_phase(input int phase);
        logic [CFG_DATA_W-1:0] spare;
        logic [BIN_W-1:0]      min_peak;
        logic [CONF_W-1:0]     gain;
        logic [CONF_W-1:0]     max_conf;
        spare = CFG_DATA_W'($urandom);
        case (phase)
            0: begin
                min_peak = '0;
                gain = '1;
                max_conf = '1;
            end
            1: begin
                min_peak = '1;
                gain = '0;
                max_conf = '0;
            end
            2: begin
                min_peak = '0;
                gain = '0;
                max_conf = '1;
            end
            default: begin
                min_peak = $urandom_range(0, 1) ? BIN_W'($urandom_range(0, 300))
                                                 : BIN_W'($urandom_range(0, 65535));
                gain = CONF_W'($urandom_range(0, 15));
                max_conf = CONF_W'($urandom_range(0, 15));
            end
        endcase
        program_register(CFG_MIN_PEAK, min_peak);
        program_register(CFG_GAIN, {spare[CFG_DATA_W-1:CONF_W], gain});
        if (phase == 3 || $urandom_range(0, 3) == 0) begin
            program_register(CFG_SPARE, CFG_DATA_W'($urandom));
        end
        program_register(CFG_MAX_CONF, {~spare[CFG_DATA_W-1:CONF_W], max_conf});
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        bin_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin : stimulus
        rst_n = 1'b0;
        bin_valid = 1'b0;
        bin_value = '0;
        bin_vertical = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MIN_PEAK;
        cfg_data = '0;
        idle_on = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        idle_on <= 1'b1;
        @(negedge clk);

        foreach (hist_bins[i]) hist_bins[i] = '0;
        send_histogram(1'b1);
        hist_bins[NUM_BINS - 1] = '1;
        send_histogram(1'b0);
        foreach (hist_bins[i]) hist_bins[i] = '1;
        send_histogram(1'b1);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            configure_phase(phase);
            idle_on <= (phase % 3 != 2) && (phase < PHASES - 2);
            repeat (HISTS_PER_PHASE) begin
                shape_histogram();
                send_histogram(1'($urandom_range(0, 1)));
            end
        end
        drain();

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/dgoe_pkg.sv
hw/rtl/dgoe_front.sv
hw/rtl/dgoe_queue.sv
hw/rtl/dgoe_divider.sv
hw/rtl/dgoe_back.sv
hw/rtl/deblock_grid_offset_estimator_top.sv
dv/grid_offset_checker.sv
dv/testbench.sv
